/* rtl/cchw_pkg.sv */
package cchw_pkg;

    // Sizing of the sample set and the feature format.
    localparam int MAX_SAMPLES = 1024;
    localparam int FEAT_W      = 24;
    localparam int FRAC_BITS   = 16;
    localparam int GUARD_BITS  = 6;
    localparam int OUT_FRAC    = 24;

    localparam int ADDR_W   = $clog2(MAX_SAMPLES);
    localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W    = FEAT_W + $clog2(MAX_SAMPLES);
    localparam int MEAN_W   = FEAT_W + 1;
    localparam int DEV_W    = FEAT_W + 2;
    localparam int SMP_W    = 3 * FEAT_W;
    localparam int ENTRY_W  = 48;
    localparam int ACC_W    = 64;
    localparam int L_W      = 32;
    localparam int DIVN_W   = 128;
    localparam int DIVD_W   = 64;
    localparam int DIV_CNT_W = $clog2(DIVN_W);
    localparam int CSHIFT   = 2 * GUARD_BITS;
    localparam int QSHIFT   = OUT_FRAC + FRAC_BITS + GUARD_BITS;

    localparam logic [DIVN_W-1:0] POS_CAP  = (DIVN_W'(1) << (ENTRY_W - 1)) - DIVN_W'(1);
    localparam logic [DIVN_W-1:0] NEG_CAP  = DIVN_W'(1) << (ENTRY_W - 1);
    localparam logic [DIVN_W-1:0] C_QLIMIT = DIVN_W'(1) << 47;
    localparam logic [DIVN_W-1:0] L_LIMIT  = DIVN_W'(1) << 30;
    localparam logic [ACC_W-1:0]  SQ_TOP   = ACC_W'(1) << (ACC_W - 2);
    localparam logic signed [ACC_W:0] SAT_HI = (ACC_W + 1)'((ACC_W + 1)'(1) << (ACC_W - 1))
                                               - (ACC_W + 1)'(1);

    // Status codes of a result run.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_NOT_PD  = 2'd2;
    localparam logic [1:0] ST_DROPPED = 2'd3;

    typedef logic [FEAT_W-1:0]  feat_t;
    typedef logic [ENTRY_W-1:0] entry_t;

    typedef struct packed {
        logic              start;
        logic [DIVN_W-1:0] num;
        logic [DIVD_W-1:0] den;
    } div_req_t;

    // Lower-triangle order: 00, 10, 11, 20, 21, 22.
    function automatic logic [1:0] tri_row(input logic [2:0] k);
        logic [1:0] r;
        unique case (k)
            3'd0:           r = 2'd0;
            3'd1, 3'd2:     r = 2'd1;
            default:        r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] tri_col(input logic [2:0] k);
        logic [1:0] c;
        unique case (k)
            3'd0, 3'd1, 3'd3: c = 2'd0;
            3'd2, 3'd4:       c = 2'd1;
            default:          c = 2'd2;
        endcase
        return c;
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                        input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W:0] s;
        logic signed [ACC_W-1:0] r;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s > SAT_HI)
            r = SAT_HI[ACC_W-1:0];
        else if (s < -SAT_HI)
            r = ACC_W'(-SAT_HI);
        else
            r = s[ACC_W-1:0];
        return r;
    endfunction

    function automatic logic [ACC_W-1:0] abs64(input logic signed [ACC_W-1:0] a);
        return a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
    endfunction

    function automatic logic [L_W-1:0] abs32(input logic signed [L_W-1:0] a);
        return a[L_W-1] ? L_W'(-a) : L_W'(a);
    endfunction

    // Clamp a quotient magnitude to the entry range and apply its sign.
    function automatic entry_t sat_entry(input logic [DIVN_W-1:0] q, input logic neg);
        logic [DIVN_W-1:0] cap;
        entry_t m;
        cap = neg ? NEG_CAP : POS_CAP;
        m = (q > cap) ? cap[ENTRY_W-1:0] : q[ENTRY_W-1:0];
        return neg ? ENTRY_W'(-m) : m;
    endfunction

endpackage

/* rtl/cchw_if.sv */
interface cchw_sample_if import cchw_pkg::*; ();
    logic  valid;
    logic  ready;
    feat_t first_feature;
    feat_t second_feature;
    feat_t third_feature;
    logic  last_sample;

    modport source (output valid, first_feature, second_feature, third_feature, last_sample,
                    input ready);
    modport sink (input valid, first_feature, second_feature, third_feature, last_sample,
                  output ready);
endinterface

interface cchw_result_if import cchw_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] row_index;
    logic [1:0] column_index;
    entry_t     entry_value;
    logic [1:0] status;
    logic       last_entry;

    modport source (output valid, row_index, column_index, entry_value, status, last_entry,
                    input ready);
    modport sink (input valid, row_index, column_index, entry_value, status, last_entry,
                  output ready);
endinterface

/* rtl/covariance_cholesky_whitening.sv */
// The covariance pass over the stored samples uses the shared multiplier, and each of
// up to 19 divisions runs on the bit-serial divider.
// Throughput: one sample word per cycle while a set is being collected; no input is
// taken from the closing word until the sixth result word has been delivered.
// Reset is asynchronous and active low; it empties the set and returns to collecting.
module covariance_cholesky_whitening import cchw_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    cchw_sample_if.sink   samples,
    cchw_result_if.source results
);

    localparam int SW = 6;
    localparam logic [SW-1:0] S_IDLE    = 6'd0;
    localparam logic [SW-1:0] S_MEAN    = 6'd1;
    localparam logic [SW-1:0] S_MEAN_ST = 6'd2;
    localparam logic [SW-1:0] S_COV_RD  = 6'd3;
    localparam logic [SW-1:0] S_COV_LD  = 6'd4;
    localparam logic [SW-1:0] S_COV_MUL = 6'd5;
    localparam logic [SW-1:0] S_COV_ACC = 6'd6;
    localparam logic [SW-1:0] S_CS      = 6'd7;
    localparam logic [SW-1:0] S_CS_ST   = 6'd8;
    localparam logic [SW-1:0] S_DIV_WT  = 6'd9;
    localparam logic [SW-1:0] S_SQ_WT   = 6'd10;
    localparam logic [SW-1:0] S_L0      = 6'd11;
    localparam logic [SW-1:0] S_L1      = 6'd12;
    localparam logic [SW-1:0] S_L1_ST   = 6'd13;
    localparam logic [SW-1:0] S_R1      = 6'd14;
    localparam logic [SW-1:0] S_R1_SQ   = 6'd15;
    localparam logic [SW-1:0] S_L3      = 6'd16;
    localparam logic [SW-1:0] S_L3_ST   = 6'd17;
    localparam logic [SW-1:0] S_L4M     = 6'd18;
    localparam logic [SW-1:0] S_L4      = 6'd19;
    localparam logic [SW-1:0] S_L4_ST   = 6'd20;
    localparam logic [SW-1:0] S_R2A     = 6'd21;
    localparam logic [SW-1:0] S_R2B     = 6'd22;
    localparam logic [SW-1:0] S_R2C     = 6'd23;
    localparam logic [SW-1:0] S_T0      = 6'd24;
    localparam logic [SW-1:0] S_T0_ST   = 6'd25;
    localparam logic [SW-1:0] S_T1      = 6'd26;
    localparam logic [SW-1:0] S_T1_ST   = 6'd27;
    localparam logic [SW-1:0] S_T2_ST   = 6'd28;
    localparam logic [SW-1:0] S_T3A     = 6'd29;
    localparam logic [SW-1:0] S_T3B     = 6'd30;
    localparam logic [SW-1:0] S_T3C     = 6'd31;
    localparam logic [SW-1:0] S_T3_ST   = 6'd32;
    localparam logic [SW-1:0] S_T4      = 6'd33;
    localparam logic [SW-1:0] S_T4_ST   = 6'd34;
    localparam logic [SW-1:0] S_T5_ST   = 6'd35;
    localparam logic [SW-1:0] S_OUT     = 6'd36;

    localparam logic [DIVN_W-1:0] ONE_SCALED = DIVN_W'(1) << QSHIFT;

    // Control state.
    logic [SW-1:0]    state_reg, state_next;
    logic [SW-1:0]    ret_reg, ret_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic [2:0]       idx_reg, idx_next;
    logic [CNT_W-1:0] s_reg, s_next;
    logic [1:0]       status_reg, status_next;
    logic [SUM_W-1:0] sum_reg [3];
    logic [SUM_W-1:0] sum_next [3];

    // Datapath registers.
    logic [MEAN_W-1:0]       mean_reg [3];
    logic [MEAN_W-1:0]       mean_next [3];
    logic signed [DEV_W-1:0] d_reg [3];
    logic signed [DEV_W-1:0] d_next [3];
    logic signed [ACC_W-1:0] cov_reg [6];
    logic signed [ACC_W-1:0] cov_next [6];
    logic signed [ACC_W-1:0] cs_reg [6];
    logic signed [ACC_W-1:0] cs_next [6];
    logic signed [L_W-1:0]   l_reg [6];
    logic signed [L_W-1:0]   l_next [6];
    entry_t                  val_reg [6];
    entry_t                  val_next [6];
    logic signed [ACC_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0] tmp_reg, tmp_next;
    logic [ACC_W-1:0]        pd_reg, pd_next;
    logic                    neg_reg, neg_next;

    // Shared units.
    logic signed [L_W-1:0] mul_a, mul_b;
    div_req_t              div_req;
    logic                  div_busy;
    logic [DIVN_W-1:0]     div_quo;
    logic                  sq_start;
    logic [ACC_W-1:0]      sq_in;
    logic [ACC_W-1:0]      sq_v_reg, sq_r_reg, sq_bit_reg;
    logic                  sq_busy_reg;
    logic [ACC_W-1:0]      sq_sum;

    // Sample store.
    logic              acc;
    logic              ram_we;
    logic              ram_re;
    logic [SMP_W-1:0]  ram_rdata;
    feat_t             rd_feat [3];

    // Derived values.
    logic [DIVN_W-1:0]       quo_hi;
    logic [47:0]             cs_hi;
    logic [ACC_W-1:0]        cs_mag;
    logic signed [ACC_W-1:0] cs_val;
    logic                    l_fail;
    logic signed [L_W-1:0]   l_val;
    logic signed [L_W-1:0]   root;
    entry_t                  ent_val;
    logic signed [ACC_W-1:0] res1, num4, diff_tmp, tmp5;

    cchw_ram #(
        .WIDTH (SMP_W),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[ADDR_W-1:0]),
        .wdata ({samples.third_feature, samples.second_feature, samples.first_feature}),
        .re    (ram_re),
        .raddr (s_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    cchw_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    assign acc     = samples.valid && samples.ready;
    assign ram_we  = acc && (cnt_reg < CNT_W'(MAX_SAMPLES));
    assign rd_feat[0] = ram_rdata[FEAT_W-1:0];
    assign rd_feat[1] = ram_rdata[2*FEAT_W-1:FEAT_W];
    assign rd_feat[2] = ram_rdata[3*FEAT_W-1:2*FEAT_W];

    // Covariance scaling: trunc(|P| * 2^12 / n) with the integer part clamped.
    assign quo_hi  = div_quo >> CSHIFT;
    assign cs_hi   = (quo_hi > C_QLIMIT) ? C_QLIMIT[47:0] : quo_hi[47:0];
    assign cs_mag  = {4'b0000, cs_hi, div_quo[CSHIFT-1:0]};
    assign cs_val  = neg_reg ? -$signed(cs_mag) : $signed(cs_mag);

    assign l_fail  = div_quo > L_LIMIT;
    assign l_val   = neg_reg ? -$signed(div_quo[L_W-1:0]) : $signed(div_quo[L_W-1:0]);
    assign root    = $signed(sq_r_reg[L_W-1:0]);
    assign ent_val = sat_entry(div_quo, neg_reg);

    assign res1     = cs_reg[2] - prod_reg;
    assign num4     = cs_reg[4] - prod_reg;
    assign tmp5     = cs_reg[5] - prod_reg;
    assign diff_tmp = tmp_reg - prod_reg;

    assign prod_next = mul_a * mul_b;
    assign sq_sum    = sq_r_reg + sq_bit_reg;

    assign samples.ready        = (state_reg == S_IDLE);
    assign results.valid        = (state_reg == S_OUT);
    assign results.row_index    = tri_row(idx_reg);
    assign results.column_index = tri_col(idx_reg);
    assign results.entry_value  = val_reg[idx_reg];
    assign results.status       = status_reg;
    assign results.last_entry   = (idx_reg == 3'd5);

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        idx_next    = idx_reg;
        s_next      = s_reg;
        status_next = status_reg;
        sum_next    = sum_reg;
        mean_next   = mean_reg;
        d_next      = d_reg;
        cov_next    = cov_reg;
        cs_next     = cs_reg;
        l_next      = l_reg;
        val_next    = val_reg;
        tmp_next    = tmp_reg;
        pd_next     = pd_reg;
        neg_next    = neg_reg;
        mul_a       = '0;
        mul_b       = '0;
        div_req     = '0;
        sq_start    = 1'b0;
        sq_in       = '0;
        ram_re      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (cnt_reg < CNT_W'(MAX_SAMPLES))
                    begin
                        sum_next[0] = sum_reg[0] + SUM_W'(samples.first_feature);
                        sum_next[1] = sum_reg[1] + SUM_W'(samples.second_feature);
                        sum_next[2] = sum_reg[2] + SUM_W'(samples.third_feature);
                        cnt_next    = cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (samples.last_sample)
                    begin
                        idx_next = '0;
                        s_next   = '0;
                        for (int k = 0; k < 6; k++)
                        begin
                            val_next[k] = '0;
                            cov_next[k] = '0;
                        end
                        if (cnt_next == '0)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            state_next = S_MEAN;
                        end
                    end
                end
            end

            S_MEAN:
            begin
                div_req.start = 1'b1;
                div_req.num   = DIVN_W'(sum_reg[idx_reg[1:0]] + SUM_W'(cnt_reg >> 1));
                div_req.den   = DIVD_W'(cnt_reg);
                ret_next      = S_MEAN_ST;
                state_next    = S_DIV_WT;
            end

            S_MEAN_ST:
            begin
                mean_next[idx_reg[1:0]] = div_quo[MEAN_W-1:0];
                if (idx_reg == 3'd2)
                begin
                    idx_next   = '0;
                    state_next = S_COV_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 3'd1;
                    state_next = S_MEAN;
                end
            end

            S_COV_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_COV_LD;
            end

            S_COV_LD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    d_next[i] = $signed({2'b00, rd_feat[i]}) - $signed({1'b0, mean_reg[i]});
                end
                state_next = S_COV_MUL;
            end

            S_COV_MUL:
            begin
                mul_a      = L_W'(d_reg[tri_row(idx_reg)]);
                mul_b      = L_W'(d_reg[tri_col(idx_reg)]);
                state_next = S_COV_ACC;
            end

            S_COV_ACC:
            begin
                cov_next[idx_reg] = sat_add(cov_reg[idx_reg], prod_reg);
                if (idx_reg == 3'd5)
                begin
                    idx_next = '0;
                    s_next   = s_reg + CNT_W'(1);
                    if (s_next == cnt_reg)
                    begin
                        state_next = S_CS;
                    end
                    else
                    begin
                        state_next = S_COV_RD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 3'd1;
                    state_next = S_COV_MUL;
                end
            end

            S_CS:
            begin
                neg_next      = cov_reg[idx_reg][ACC_W-1];
                div_req.start = 1'b1;
                div_req.num   = DIVN_W'(abs64(cov_reg[idx_reg])) << CSHIFT;
                div_req.den   = DIVD_W'(cnt_reg);
                ret_next      = S_CS_ST;
                state_next    = S_DIV_WT;
            end

            S_CS_ST:
            begin
                cs_next[idx_reg] = cs_val;
                if (idx_reg == 3'd5)
                begin
                    idx_next   = '0;
                    state_next = S_L0;
                end
                else
                begin
                    idx_next   = idx_reg + 3'd1;
                    state_next = S_CS;
                end
            end

            S_DIV_WT:
            begin
                if (!div_busy)
                begin
                    state_next = ret_reg;
                end
            end

            S_SQ_WT:
            begin
                if (!sq_busy_reg)
                begin
                    state_next = ret_reg;
                end
            end

            S_L0:
            begin
                if (cs_reg[0] <= 0)
                begin
                    status_next = ST_NOT_PD;
                    state_next  = S_OUT;
                end
                else
                begin
                    sq_start   = 1'b1;
                    sq_in      = ACC_W'(cs_reg[0]);
                    ret_next   = S_L1;
                    state_next = S_SQ_WT;
                end
            end

            S_L1:
            begin
                l_next[0]     = root;
                neg_next      = cs_reg[1][ACC_W-1];
                div_req.start = 1'b1;
                div_req.num   = DIVN_W'(abs64(cs_reg[1]));
                div_req.den   = DIVD_W'($unsigned(root));
                ret_next      = S_L1_ST;
                state_next    = S_DIV_WT;
            end

            S_L1_ST:
            begin
                if (l_fail)
                begin
                    status_next = ST_NOT_PD;
                    state_next  = S_OUT;
                end
                else
                begin
                    l_next[1]  = l_val;
                    state_next = S_R1;
                end
            end

            S_R1:
            begin
                mul_a      = l_reg[1];
                mul_b      = l_reg[1];
                state_next = S_R1_SQ;
            end

            S_R1_SQ:
            begin
                if (res1 <= 0)
                begin
                    status_next = ST_NOT_PD;
                    state_next  = S_OUT;
                end
                else
                begin
                    sq_start   = 1'b1;
                    sq_in      = ACC_W'(res1);
                    ret_next   = S_L3;
                    state_next = S_SQ_WT;
                end
            end

            S_L3:
            begin
                l_next[2]     = root;
                neg_next      = cs_reg[3][ACC_W-1];
                div_req.start = 1'b1;
                div_req.num   = DIVN_W'(abs64(cs_reg[3]));
                div_req.den   = DIVD_W'($unsigned(l_reg[0]));
                ret_next      = S_L3_ST;
                state_next    = S_DIV_WT;
            end

            S_L3_ST:
            begin
                if (l_fail)
                begin
                    status_next = ST_NOT_PD;
                    state_next  = S_OUT;
                end
                else
                begin
                    l_next[3]  = l_val;
                    state_next = S_L4M;
                end
            end

            S_L4M:
            begin
                mul_a      = l_reg[3];
                mul_b      = l_reg[1];
                state_next = S_L4;
            end

            S_L4:
            begin
                neg_next      = num4[ACC_W-1];
                div_req.start = 1'b1;
                div_req.num   = DIVN_W'(abs64(num4));
                div_req.den   = DIVD_W'($unsigned(l_reg[2]));
                ret_next      = S_L4_ST;
                state_next    = S_DIV_WT;
            end

            S_L4_ST:
            begin
                if (l_fail)
                begin
                    status_next = ST_NOT_PD;
                    state_next  = S_OUT;
                end
                else
                begin
                    l_next[4]  = l_val;
                    state_next = S_R2A;
                end
            end

            S_R2A:
            begin
                mul_a      = l_reg[3];
                mul_b      = l_reg[3];
                state_next = S_R2B;
            end

            S_R2B:
            begin
                tmp_next   = tmp5;
                mul_a      = l_reg[4];
                mul_b      = l_reg[4];
                state_next = S_R2C;
            end

            S_R2C:
            begin
                if (diff_tmp <= 0)
                begin
                    status_next = ST_NOT_PD;
                    state_next  = S_OUT;
                end
                else
                begin
                    sq_start   = 1'b1;
                    sq_in      = ACC_W'(diff_tmp);
                    ret_next   = S_T0;
                    state_next = S_SQ_WT;
                end
            end

            // The factor is complete: invert it entry by entry.
            S_T0:
            begin
                l_next[5]     = root;
                status_next   = ovf_reg ? ST_DROPPED : ST_OK;
                neg_next      = 1'b0;
                div_req.start = 1'b1;
                div_req.num   = ONE_SCALED;
                div_req.den   = DIVD_W'($unsigned(l_reg[0]));
                ret_next      = S_T0_ST;
                state_next    = S_DIV_WT;
            end

            S_T0_ST:
            begin
                val_next[0] = ent_val;
                mul_a       = l_reg[0];
                mul_b       = l_reg[2];
                state_next  = S_T1;
            end

            S_T1:
            begin
                pd_next       = ACC_W'(prod_reg);
                neg_next      = (l_reg[1] > 0);
                div_req.start = 1'b1;
                div_req.num   = DIVN_W'(abs32(l_reg[1])) << QSHIFT;
                div_req.den   = DIVD_W'(prod_reg);
                ret_next      = S_T1_ST;
                state_next    = S_DIV_WT;
            end

            S_T1_ST:
            begin
                val_next[1]   = ent_val;
                neg_next      = 1'b0;
                div_req.start = 1'b1;
                div_req.num   = ONE_SCALED;
                div_req.den   = DIVD_W'($unsigned(l_reg[2]));
                ret_next      = S_T2_ST;
                state_next    = S_DIV_WT;
            end

            S_T2_ST:
            begin
                val_next[2] = ent_val;
                mul_a       = l_reg[1];
                mul_b       = l_reg[4];
                state_next  = S_T3A;
            end

            S_T3A:
            begin
                tmp_next   = prod_reg;
                mul_a      = l_reg[2];
                mul_b      = l_reg[3];
                state_next = S_T3B;
            end

            S_T3B:
            begin
                neg_next      = diff_tmp[ACC_W-1];
                div_req.start = 1'b1;
                div_req.num   = DIVN_W'(abs64(diff_tmp)) << QSHIFT;
                div_req.den   = pd_reg;
                ret_next      = S_T3C;
                state_next    = S_DIV_WT;
            end

            // Second division of the corner entry, by the last diagonal.
            S_T3C:
            begin
                div_req.start = 1'b1;
                div_req.num   = div_quo;
                div_req.den   = DIVD_W'($unsigned(l_reg[5]));
                ret_next      = S_T3_ST;
                state_next    = S_DIV_WT;
            end

            S_T3_ST:
            begin
                val_next[3] = ent_val;
                mul_a       = l_reg[2];
                mul_b       = l_reg[5];
                state_next  = S_T4;
            end

            S_T4:
            begin
                neg_next      = (l_reg[4] > 0);
                div_req.start = 1'b1;
                div_req.num   = DIVN_W'(abs32(l_reg[4])) << QSHIFT;
                div_req.den   = DIVD_W'(prod_reg);
                ret_next      = S_T4_ST;
                state_next    = S_DIV_WT;
            end

            S_T4_ST:
            begin
                val_next[4]   = ent_val;
                neg_next      = 1'b0;
                div_req.start = 1'b1;
                div_req.num   = ONE_SCALED;
                div_req.den   = DIVD_W'($unsigned(l_reg[5]));
                ret_next      = S_T5_ST;
                state_next    = S_DIV_WT;
            end

            S_T5_ST:
            begin
                val_next[5] = ent_val;
                idx_next    = '0;
                state_next  = S_OUT;
            end

            S_OUT:
            begin
                if (results.ready)
                begin
                    if (idx_reg == 3'd5)
                    begin
                        idx_next   = '0;
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        sum_next   = '{default: '0};
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A failed check jumps straight to the result run from the first word.
        if (state_next == S_OUT && state_reg != S_OUT)
        begin
            idx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            idx_reg     <= '0;
            s_reg       <= '0;
            status_reg  <= ST_OK;
            sum_reg     <= '{default: '0};
            sq_busy_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            cnt_reg    <= cnt_next;
            ovf_reg    <= ovf_next;
            idx_reg    <= idx_next;
            s_reg      <= s_next;
            status_reg <= status_next;
            sum_reg    <= sum_next;
            if (sq_start)
            begin
                sq_busy_reg <= 1'b1;
            end
            else if (sq_busy_reg && sq_bit_reg == ACC_W'(1))
            begin
                sq_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mean_reg <= mean_next;
        d_reg    <= d_next;
        cov_reg  <= cov_next;
        cs_reg   <= cs_next;
        l_reg    <= l_next;
        val_reg  <= val_next;
        prod_reg <= prod_next;
        tmp_reg  <= tmp_next;
        pd_reg   <= pd_next;
        neg_reg  <= neg_next;
    end

    // Integer square root, two radicand bits per cycle.
    always_ff @(posedge clk)
    begin
        if (sq_start)
        begin
            sq_v_reg   <= sq_in;
            sq_r_reg   <= '0;
            sq_bit_reg <= SQ_TOP;
        end
        else if (sq_busy_reg)
        begin
            if (sq_v_reg >= sq_sum)
            begin
                sq_v_reg <= sq_v_reg - sq_sum;
                sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
            end
            else
            begin
                sq_r_reg <= sq_r_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end
    end

endmodule

/* rtl/cchw_ram.sv */
module cchw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/cchw_div.sv */
module cchw_div import cchw_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  div_req_t          req,
    output logic              busy,
    output logic [DIVN_W-1:0] quo
);

    logic [DIVD_W-1:0]    rem_reg;
    logic [DIVN_W-1:0]    work_reg;
    logic [DIVD_W-1:0]    den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic [DIVD_W:0]      trial;
    logic [DIVD_W:0]      diff;
    logic                 ge;

    // One quotient bit per cycle, most significant first; the dividend shifts
    // out of the top of the work word as quotient bits enter at the bottom.
    assign trial = {rem_reg, work_reg[DIVN_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIVN_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= '0;
            work_reg <= req.num;
            den_reg  <= req.den;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff[DIVD_W-1:0] : trial[DIVD_W-1:0];
            work_reg <= {work_reg[DIVN_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign quo  = work_reg;

endmodule

/* rtl/cchw_checker.sv */
module cchw_checker import cchw_pkg::*; (
    input logic           clk,
    input logic           rst_n,
    cchw_sample_if.sink   samples,
    cchw_result_if.source results
);

    // A held result word keeps its value, row index and status.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.ready |=> $stable(results.entry_value)
            && $stable(results.row_index) && $stable(results.status))
        else $error("result word changed while stalled");

    // Collecting and delivering never overlap.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(samples.ready && results.valid))
        else $error("input taken while results pending");

    // Only the lower triangle is reported.
    a_tri: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> results.column_index <= results.row_index)
        else $error("entry above the diagonal");

    // A run does not break off before its final word.
    a_run: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.ready && !results.last_entry |=> results.valid)
        else $error("result run interrupted");

    // After the final word the block collects again.
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.ready && results.last_entry |=> samples.ready)
        else $error("no return to collecting after the run");

endmodule

bind covariance_cholesky_whitening cchw_checker u_cchw_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .samples (samples),
    .results (results)
);

/* bench/tb_covariance_cholesky_whitening.sv */
`timescale 1ns / 100ps

module tb_covariance_cholesky_whitening;
    import cchw_pkg::*;

    localparam int WATCHDOG_LIMIT = 150000;
    localparam int TAIL_CYCLES    = 60;
    localparam int RANDOM_ITEMS   = 164;

    typedef struct {
        logic [1:0]  row;
        logic [1:0]  col;
        entry_t      value;
        logic [1:0]  status;
        logic        last;
    } entry_rec_t;

    typedef struct {
        feat_t f0;
        feat_t f1;
        feat_t f2;
        logic  last;
        bit    typed_not_pd;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cchw_sample_if smp ();
    cchw_result_if res ();

    covariance_cholesky_whitening DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (smp.sink),
        .results (res.source)
    );

    always #5 clk = ~clk;

    // Predictor state for the set being collected.
    int unsigned        set_feats [MAX_SAMPLES][3];
    int unsigned        set_count;
    bit                 set_dropped;
    longint unsigned    set_sums [3];

    entry_rec_t whitening_entries_q [$];

    int src_idle_pct;
    int snk_stall_pct;
    int errors;
    int mismatches;
    int idle_cycles;
    int entries_seen;
    int sets_sent;
    int status_hits [4];

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint acc_sat(input longint a, input longint b);
        logic signed [64:0] s;
        s = 65'(signed'(a)) + 65'(signed'(b));
        if (s > 65'sd9223372036854775807)
            return 64'sh7FFF_FFFF_FFFF_FFFF;
        else if (s < -65'sd9223372036854775807)
            return -64'sh7FFF_FFFF_FFFF_FFFF;
        return s[63:0];
    endfunction

    // Truncated, saturated num * 2^QSHIFT / (d1 * d2) as a 48-bit pattern.
    function automatic entry_t transform_quot(input longint num, input longint unsigned d1,
                                              input longint unsigned d2);
        logic [127:0] q;
        logic [127:0] cap;
        logic         neg;
        neg = num < 0;
        q = 128'(neg ? 64'(-num) : 64'(num)) << QSHIFT;
        q = q / 128'(d1);
        q = q / 128'(d2);
        cap = neg ? NEG_CAP : POS_CAP;
        if (q > cap)
            q = cap;
        return neg ? entry_t'(-q[47:0]) : q[47:0];
    endfunction

    task automatic predict_sample(input feat_t f0, input feat_t f1, input feat_t f2,
                                  input logic last);
        longint          mean [3];
        longint          cov [6];
        longint          cs [6];
        longint          fac [6];
        longint          d [3];
        longint          rsd;
        longint unsigned n;
        longint unsigned m;
        longint unsigned q;
        longint unsigned r;
        longint unsigned c;
        entry_t          vals [6];
        logic [1:0]      st;
        int              rows [6];
        int              cols [6];
        entry_rec_t      rec;
        rows = '{0, 1, 1, 2, 2, 2};
        cols = '{0, 0, 1, 0, 1, 2};
        if (set_count < MAX_SAMPLES)
        begin
            set_feats[set_count][0] = f0;
            set_feats[set_count][1] = f1;
            set_feats[set_count][2] = f2;
            set_sums[0] += f0;
            set_sums[1] += f1;
            set_sums[2] += f2;
            set_count++;
        end
        else
            set_dropped = 1'b1;
        if (!last)
            return;
        foreach (vals[k])
            vals[k] = '0;
        n = set_count;
        if (n == 0)
            st = ST_EMPTY;
        else
        begin
            for (int i = 0; i < 3; i++)
                mean[i] = longint'((set_sums[i] + n / 2) / n);
            foreach (cov[k])
                cov[k] = 0;
            for (int s = 0; s < set_count; s++)
            begin
                for (int i = 0; i < 3; i++)
                    d[i] = longint'(set_feats[s][i]) - mean[i];
                for (int k = 0; k < 6; k++)
                    cov[k] = acc_sat(cov[k], d[rows[k]] * d[cols[k]]);
            end
            for (int k = 0; k < 6; k++)
            begin
                m = cov[k] < 0 ? 64'(-cov[k]) : 64'(cov[k]);
                q = m / n;
                r = m % n;
                if (q > C_QLIMIT[63:0])
                    q = C_QLIMIT[63:0];
                c = (q << CSHIFT) + ((r << CSHIFT) / n);
                cs[k] = cov[k] < 0 ? -longint'(c) : longint'(c);
            end
            foreach (fac[k])
                fac[k] = 0;
            st = ST_NOT_PD;
            do
            begin
                if (cs[0] <= 0) break;
                fac[0] = longint'(root_floor(cs[0]));
                fac[1] = cs[1] / fac[0];
                if (fac[1] > (64'sd1 << 30) || fac[1] < -(64'sd1 << 30)) break;
                rsd = cs[2] - fac[1] * fac[1];
                if (rsd <= 0) break;
                fac[2] = longint'(root_floor(rsd));
                fac[3] = cs[3] / fac[0];
                if (fac[3] > (64'sd1 << 30) || fac[3] < -(64'sd1 << 30)) break;
                fac[4] = (cs[4] - fac[3] * fac[1]) / fac[2];
                if (fac[4] > (64'sd1 << 30) || fac[4] < -(64'sd1 << 30)) break;
                rsd = cs[5] - fac[3] * fac[3] - fac[4] * fac[4];
                if (rsd <= 0) break;
                fac[5] = longint'(root_floor(rsd));
                st = set_dropped ? ST_DROPPED : ST_OK;
            end
            while (0);
            if (st == ST_OK || st == ST_DROPPED)
            begin
                vals[0] = transform_quot(1, fac[0], 1);
                vals[1] = transform_quot(-fac[1], fac[0] * fac[2], 1);
                vals[2] = transform_quot(1, fac[2], 1);
                vals[3] = transform_quot(fac[1] * fac[4] - fac[2] * fac[3],
                                         fac[0] * fac[2], fac[5]);
                vals[4] = transform_quot(-fac[4], fac[2] * fac[5], 1);
                vals[5] = transform_quot(1, fac[5], 1);
            end
        end
        for (int k = 0; k < 6; k++)
        begin
            rec.row    = 2'(rows[k]);
            rec.col    = 2'(cols[k]);
            rec.value  = vals[k];
            rec.status = st;
            rec.last   = (k == 5);
            whitening_entries_q.insert(whitening_entries_q.size(), rec);
        end
        set_count = 0;
        set_dropped = 1'b0;
        set_sums = '{0, 0, 0};
    endtask

    task automatic send_sample(input feat_t f0, input feat_t f1, input feat_t f2,
                               input logic last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            smp.valid <= 1'b0;
            @(posedge clk);
        end
        smp.valid          <= 1'b1;
        smp.first_feature  <= f0;
        smp.second_feature <= f1;
        smp.third_feature  <= f2;
        smp.last_sample    <= last;
        do
            @(posedge clk);
        while (!(smp.valid && smp.ready));
        predict_sample(f0, f1, f2, last);
    endtask

    task automatic drain_results();
        while (whitening_entries_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_phase(input int set_no);
        case ((set_no / 5) % 4)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 80; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 80; end
            default: begin src_idle_pct = 15; snk_stall_pct = 15; end
        endcase
    endtask

    function automatic feat_t random_feature(input int shape);
        feat_t v;
        case (shape)
            0: v = feat_t'($urandom);
            1: v = feat_t'($urandom_range(255));
            2: v = feat_t'(24'h800000 + $urandom_range(4095) - 2048);
            default: v = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
        endcase
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else
            res.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Result checker and watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((smp.valid && smp.ready) || (res.valid && res.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired with %0d result words outstanding",
                         whitening_entries_q.size());
                $display("DONE: errors detected");
                $finish;
            end
            if (res.valid && res.ready)
            begin
                entries_seen++;
                if (whitening_entries_q.size() == 0)
                begin
                    errors++;
                    $display("Unexpected result word (%0d,%0d) value %h status %0d",
                             res.row_index, res.column_index, res.entry_value, res.status);
                end
                else
                begin
                    entry_rec_t e;
                    e = whitening_entries_q.pop_front();
                    status_hits[e.status]++;
                    if (res.row_index !== e.row || res.column_index !== e.col ||
                        res.entry_value !== e.value || res.status !== e.status ||
                        res.last_entry !== e.last)
                    begin
                        errors++;
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("Mismatch: expected (%0d,%0d) %h st %0d last %0d",
                                     e.row, e.col, e.value, e.status, e.last);
                            $display("          got      (%0d,%0d) %h st %0d last %0d",
                                     res.row_index, res.column_index, res.entry_value,
                                     res.status, res.last_entry);
                        end
                    end
                end
            end
        end
    end

    initial
    begin
        stim_row_t dir_rows [$];
        int        items;
        int        set_size;
        int        shape;
        int        base_q;

        smp.valid = 1'b0;
        smp.first_feature = '0;
        smp.second_feature = '0;
        smp.third_feature = '0;
        smp.last_sample = 1'b0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        errors = 0;
        mismatches = 0;
        idle_cycles = 0;
        entries_seen = 0;
        sets_sent = 0;
        status_hits = '{0, 0, 0, 0};
        set_count = 0;
        set_dropped = 1'b0;
        set_sums = '{0, 0, 0};

        // A single sample, or identical samples, have no spread and cannot factor.
        dir_rows = '{
            '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1},
            '{24'h000000, 24'h000000, 24'h000000, 1'b1, 1'b1},
            '{24'h123456, 24'h654321, 24'hABCDEF, 1'b0, 1'b0},
            '{24'h123456, 24'h654321, 24'hABCDEF, 1'b1, 1'b1},
            '{24'hFFFFFF, 24'h000000, 24'h000000, 1'b0, 1'b0},
            '{24'h000000, 24'hFFFFFF, 24'h000000, 1'b0, 1'b0},
            '{24'h000000, 24'h000000, 24'hFFFFFF, 1'b1, 1'b0},
            '{24'h010000, 24'h020000, 24'h030000, 1'b0, 1'b0},
            '{24'h0F0000, 24'h001000, 24'h800000, 1'b0, 1'b0},
            '{24'hFFFFFF, 24'h7FFFFF, 24'h000001, 1'b0, 1'b0},
            '{24'h000100, 24'hABCDEF, 24'h555555, 1'b1, 1'b0},
            '{24'h000000, 24'h000000, 24'h000000, 1'b0, 1'b0},
            '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b0},
            '{24'h000000, 24'hFFFFFF, 24'h5A5A5A, 1'b0, 1'b0},
            '{24'hFFFFFF, 24'h000000, 24'hA5A5A5, 1'b0, 1'b0},
            '{24'h800000, 24'h800000, 24'h0F0F0F, 1'b1, 1'b0}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_sample(dir_rows[i].f0, dir_rows[i].f1, dir_rows[i].f2, dir_rows[i].last);
            if (dir_rows[i].typed_not_pd)
            begin
                // The six words of the set just closed are the last ones queued.
                base_q = whitening_entries_q.size() - 6;
                for (int k = 0; k < 6; k++)
                    whitening_entries_q[base_q + k].value = '0;
                for (int k = 0; k < 6; k++)
                    whitening_entries_q[base_q + k].status = ST_NOT_PD;
            end
            if (dir_rows[i].last)
                sets_sent++;
        end
        smp.valid <= 1'b0;
        // Hold the sender off until every word of the directed sets is home.
        drain_results();

        items = 0;
        while (items < RANDOM_ITEMS)
        begin
            set_phase(sets_sent);
            set_size = $urandom_range(9) < 8 ? $urandom_range(8, 3) : $urandom_range(2, 1);
            shape = $urandom_range(3);
            for (int s = 0; s < set_size; s++)
            begin
                send_sample(random_feature(shape), random_feature(shape),
                            random_feature($urandom_range(3)), s == set_size - 1);
                items++;
            end
            sets_sent++;
            if (sets_sent % 5 == 0)
            begin
                smp.valid <= 1'b0;
                drain_results();
            end
        end
        smp.valid <= 1'b0;

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d sample sets, checked %0d result words", sets_sent, entries_seen);
        $display("Status counts: ok %0d, empty %0d, not positive definite %0d, dropped %0d",
                 status_hits[0] / 6, status_hits[1] / 6, status_hits[2] / 6,
                 status_hits[3] / 6);
        if (errors == 0 && whitening_entries_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
rtl/cchw_pkg.sv
rtl/cchw_if.sv
rtl/cchw_ram.sv
rtl/cchw_div.sv
rtl/covariance_cholesky_whitening.sv
rtl/cchw_checker.sv
bench/tb_covariance_cholesky_whitening.sv
